// ===== hw/rtl/dtdiff_pkg.sv =====
`default_nettype none

package dtdiff_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DAYS_W  = 22;
   localparam int ERR_W   = 2;
   localparam int DNUM_W  = 23;
   localparam int ERA_W   = 6;
   localparam int YOE_W   = 9;
   localparam int DOY_W   = 9;
   localparam int DOE_W   = 18;
   localparam int Q25_W   = 10;

   localparam int PIPE_DEPTH = 4;

   localparam int unsigned MAX_YEAR_DEF = 9999;

   // x / 25 == (x * DIV25_MUL) >> DIV25_SHIFT for x < 43690
   localparam logic [14:0] DIV25_MUL   = 15'd20972;
   localparam int          DIV25_SHIFT = 19;

   localparam logic [DOE_W-1:0] DAYS_PER_ERA = 18'd146097;

   localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FIRST  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SECOND = 2'd2;
   localparam logic [ERR_W-1:0] ERR_ORDER  = 2'd3;

   typedef struct packed {
      logic [DNUM_W-1:0] day_num;
      logic              valid;
      logic              leap;
   } date_info_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before shifted month (March = 0)
   function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] mp);
      logic [DOY_W-1:0] ofs;
      case (mp)
         4'd0:    ofs = 9'd0;
         4'd1:    ofs = 9'd31;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd92;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd153;
         4'd6:    ofs = 9'd184;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd245;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd306;
         4'd11:   ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dtdiff_date_unit.sv =====
`default_nettype none

module dtdiff_date_unit #(
   parameter int unsigned MAX_YEAR = dtdiff_pkg::MAX_YEAR_DEF
) (
   input  wire logic                         clock,
   input  wire logic [dtdiff_pkg::DAY_W-1:0]   day,
   input  wire logic [dtdiff_pkg::MONTH_W-1:0] month,
   input  wire logic [dtdiff_pkg::YEAR_W-1:0]  year,
   output dtdiff_pkg::date_info_type           info
);
   import dtdiff_pkg::*;

   localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);
   localparam int PROD_Y_W = YEAR_W + 15;
   localparam int PROD_E_W = YEAR_W - 4 + 15;

   // stage 1: year split, divide by 25
   logic [YEAR_W-1:0]   yy_in;
   logic [PROD_Y_W-1:0] prod_y;
   logic [PROD_E_W-1:0] prod_e;
   logic [MONTH_W-1:0]  mp_in;
   logic                mok_in, yok_in;

   logic [YEAR_W-1:0]  y_ff, yy_ff;
   logic [Q25_W-1:0]   q25_ff;
   logic [ERA_W-1:0]   era1_ff;
   logic [MONTH_W-1:0] mp_ff, m_ff;
   logic [DAY_W-1:0]   d_ff;
   logic               mok_ff, yok_ff;

   always_comb begin
      yy_in  = (month <= 4'd2) ? year - 14'd1 : year;
      prod_y = PROD_Y_W'(year) * PROD_Y_W'(DIV25_MUL);
      prod_e = PROD_E_W'(yy_in[YEAR_W-1:4]) * PROD_E_W'(DIV25_MUL);
      mp_in  = (month > 4'd2) ? month - 4'd3 : month + 4'd9;
      mok_in = (month >= 4'd1) && (month <= 4'd12);
      yok_in = (year != '0) && (year <= MAX_YEAR_V);
   end

   always_ff @(posedge clock) begin
      y_ff    <= year;
      yy_ff   <= yy_in;
      q25_ff  <= prod_y[DIV25_SHIFT +: Q25_W];
      era1_ff <= prod_e[DIV25_SHIFT +: ERA_W];
      mp_ff   <= mp_in;
      m_ff    <= month;
      d_ff    <= day;
      mok_ff  <= mok_in;
      yok_ff  <= yok_in;
   end

   // stage 2: leap rule, day check, year of era, day of year
   logic [14:0]        q25x25;
   logic [14:0]        era400;
   logic [14:0]        yoe_wide;
   logic               leap_in, valid2_in;
   logic [DAY_W-1:0]   len;
   logic [DOY_W-1:0]   doy_in;

   logic               valid2_ff, leap2_ff;
   logic [YOE_W-1:0]   yoe_ff;
   logic [DOY_W-1:0]   doy_ff;
   logic [ERA_W-1:0]   era2_ff;

   always_comb begin
      q25x25    = {q25_ff, 4'd0} + {1'b0, q25_ff, 3'd0} + {5'd0, q25_ff};
      leap_in   = (y_ff[1:0] == 2'd0) &&
                  ((y_ff[3:0] == 4'd0) || (q25x25 != {1'b0, y_ff}));
      len       = month_len(m_ff, leap_in);
      valid2_in = mok_ff && yok_ff && (d_ff != '0) && (d_ff <= len);
      era400    = {1'b0, era1_ff, 8'd0} + {2'b0, era1_ff, 7'd0} + {5'd0, era1_ff, 4'd0};
      yoe_wide  = {1'b0, yy_ff} - era400;
      doy_in    = month_offset(mp_ff) + DOY_W'(d_ff) - 9'd1;
   end

   always_ff @(posedge clock) begin
      valid2_ff <= valid2_in;
      leap2_ff  <= leap_in;
      yoe_ff    <= yoe_wide[YOE_W-1:0];
      doy_ff    <= doy_in;
      era2_ff   <= era1_ff;
   end

   // stage 3: day of era, era offset
   logic [1:0]          cent;
   logic [DOE_W-1:0]    doe_in;
   logic [DNUM_W-1:0]   era_days_in;

   logic [DOE_W-1:0]    doe_ff;
   logic [DNUM_W-1:0]   era_days_ff;
   logic                valid3_ff, leap3_ff;

   always_comb begin
      if (yoe_ff >= 9'd300) begin
         cent = 2'd3;
      end else if (yoe_ff >= 9'd200) begin
         cent = 2'd2;
      end else if (yoe_ff >= 9'd100) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      doe_in = DOE_W'(yoe_ff) * 18'd365 + DOE_W'(yoe_ff[YOE_W-1:2])
               - DOE_W'(cent) + DOE_W'(doy_ff);
      era_days_in = DNUM_W'(era2_ff) * DNUM_W'(DAYS_PER_ERA);
   end

   always_ff @(posedge clock) begin
      doe_ff      <= doe_in;
      era_days_ff <= era_days_in;
      valid3_ff   <= valid2_ff;
      leap3_ff    <= leap2_ff;
   end

   // stage 4: day number
   date_info_type info_in, info_ff;

   always_comb begin
      info_in.day_num = era_days_ff + DNUM_W'(doe_ff);
      info_in.valid   = valid3_ff;
      info_in.leap    = leap3_ff;
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
   end

   assign info = info_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dtdiff_compare.sv =====
`default_nettype none

module dtdiff_compare (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire dtdiff_pkg::date_info_type  first,
   input  wire dtdiff_pkg::date_info_type  second,
   output logic                            out_valid,
   output logic [dtdiff_pkg::DAYS_W-1:0]   days_between,
   output logic [dtdiff_pkg::ERR_W-1:0]    error_code,
   output logic                            first_is_leap,
   output logic                            second_is_leap
);
   import dtdiff_pkg::*;

   logic [DNUM_W:0]     diff;
   logic [DAYS_W-1:0]   days_in;
   logic [ERR_W-1:0]    err_in;

   logic                valid_ff;
   logic [DAYS_W-1:0]   days_ff;
   logic [ERR_W-1:0]    err_ff;
   logic                leap1_ff, leap2_ff;

   always_comb begin
      diff    = {1'b0, second.day_num} - {1'b0, first.day_num};
      days_in = '0;
      if (!first.valid) begin
         err_in = ERR_FIRST;
      end else if (!second.valid) begin
         err_in = ERR_SECOND;
      end else if (diff[DNUM_W]) begin
         err_in = ERR_ORDER;
      end else begin
         err_in  = ERR_OK;
         days_in = (diff[DNUM_W-1:DAYS_W] != '0) ? '1 : diff[DAYS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      days_ff  <= days_in;
      err_ff   <= err_in;
      leap1_ff <= first.leap;
      leap2_ff <= second.leap;
   end

   assign out_valid      = valid_ff;
   assign days_between   = days_ff;
   assign error_code     = err_ff;
   assign first_is_leap  = leap1_ff;
   assign second_is_leap = leap2_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/date_difference_in_days.sv =====
// A request taken at a clock edge passes five register stages before its result
// is shown with rsp_valid high.
// Throughput: one request per cycle; busy is high only during reset.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (synchronous, active high) clears all in-flight requests.
`default_nettype none

module date_difference_in_days #(
   parameter int unsigned MAX_YEAR = dtdiff_pkg::MAX_YEAR_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [dtdiff_pkg::DAY_W-1:0]   req_first_day,
   input  wire logic [dtdiff_pkg::MONTH_W-1:0] req_first_month,
   input  wire logic [dtdiff_pkg::YEAR_W-1:0]  req_first_year,
   input  wire logic [dtdiff_pkg::DAY_W-1:0]   req_second_day,
   input  wire logic [dtdiff_pkg::MONTH_W-1:0] req_second_month,
   input  wire logic [dtdiff_pkg::YEAR_W-1:0]  req_second_year,
   output logic                                rsp_valid,
   output logic [dtdiff_pkg::DAYS_W-1:0]       rsp_days_between,
   output logic [dtdiff_pkg::ERR_W-1:0]        rsp_error_code,
   output logic                                rsp_first_is_leap,
   output logic                                rsp_second_is_leap
);
   import dtdiff_pkg::*;

   logic [PIPE_DEPTH-1:0] stage_vld_ff, stage_vld_in;
   date_info_type         first_info, second_info;

   assign busy = reset;

   assign stage_vld_in = {stage_vld_ff[PIPE_DEPTH-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   dtdiff_date_unit #(
      .MAX_YEAR(MAX_YEAR)
   ) u_first (
      .clock (clock),
      .day   (req_first_day),
      .month (req_first_month),
      .year  (req_first_year),
      .info  (first_info)
   );

   dtdiff_date_unit #(
      .MAX_YEAR(MAX_YEAR)
   ) u_second (
      .clock (clock),
      .day   (req_second_day),
      .month (req_second_month),
      .year  (req_second_year),
      .info  (second_info)
   );

   dtdiff_compare u_compare (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_vld_ff[PIPE_DEPTH-1]),
      .first          (first_info),
      .second         (second_info),
      .out_valid      (rsp_valid),
      .days_between   (rsp_days_between),
      .error_code     (rsp_error_code),
      .first_is_leap  (rsp_first_is_leap),
      .second_is_leap (rsp_second_is_leap)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/dtdiff_checker.sv =====
`default_nettype none

module dtdiff_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           busy,
   input  wire logic [dtdiff_pkg::YEAR_W-1:0]  req_first_year,
   input  wire logic [dtdiff_pkg::YEAR_W-1:0]  req_second_year,
   input  wire logic                           rsp_valid,
   input  wire logic [dtdiff_pkg::DAYS_W-1:0]  rsp_days_between,
   input  wire logic [dtdiff_pkg::ERR_W-1:0]   rsp_error_code,
   input  wire logic                           rsp_first_is_leap,
   input  wire logic                           rsp_second_is_leap
);
   import dtdiff_pkg::*;

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("request without result");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 5))
      else $error("result without request");

   a_err_zero_days: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_OK)) |-> (rsp_days_between == '0))
      else $error("nonzero day count on error");

   a_same_year_leap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_first_year, 5) == $past(req_second_year, 5)))
      |-> (rsp_first_is_leap == rsp_second_is_leap))
      else $error("leap flags differ for equal years");

endmodule

bind date_difference_in_days dtdiff_checker u_dtdiff_checker (.*);

`default_nettype wire

// ===== sim/date_difference_in_days_tb.sv =====
`timescale 1ns / 1ps

module date_difference_in_days_tb;

   import dtdiff_pkg::*;

   localparam int unsigned YEAR_LIMIT = MAX_YEAR_DEF;
   localparam int unsigned DAYS_SAT   = (1 << DAYS_W) - 1;
   localparam int          N_DIRECTED = 25;
   localparam int          N_RANDOM   = 400;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } cal_date_type;

   typedef struct packed {
      cal_date_type first;
      cal_date_type second;
   } date_pair_type;

   typedef struct packed {
      logic [DAYS_W-1:0] days_between;
      logic [ERR_W-1:0]  error_code;
      logic              first_is_leap;
      logic              second_is_leap;
   } day_count_type;

   typedef struct packed {
      date_pair_type pair;
      logic          typed;
      day_count_type res;
   } stim_row_type;

   localparam day_count_type NO_RES = '0;

   localparam int unsigned EDGE_YEARS [12] = '{
      0, 1, 2, 4, 100, 400, 1900, 2000, 2100, 9999, 10000, 16383
   };

   // typed rows: extremes and error codes; the rest go through the predictor
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{'{'{5'd1, 4'd1, 14'd1}, '{5'd31, 4'd12, 14'd9999}}, 1'b1,
        '{22'd3652058, ERR_OK, 1'b0, 1'b0}},
      '{'{'{5'd1, 4'd1, 14'd1}, '{5'd1, 4'd1, 14'd1}}, 1'b1,
        '{22'd0, ERR_OK, 1'b0, 1'b0}},
      '{'{'{5'd31, 4'd12, 14'd9999}, '{5'd31, 4'd12, 14'd9999}}, 1'b1,
        '{22'd0, ERR_OK, 1'b0, 1'b0}},
      '{'{'{5'd31, 4'd12, 14'd9999}, '{5'd1, 4'd1, 14'd1}}, 1'b1,
        '{22'd0, ERR_ORDER, 1'b0, 1'b0}},
      '{'{'{5'd0, 4'd1, 14'd2000}, '{5'd1, 4'd1, 14'd2000}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b1, 1'b1}},
      '{'{'{5'd1, 4'd0, 14'd2001}, '{5'd1, 4'd1, 14'd2001}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b0, 1'b0}},
      '{'{'{5'd1, 4'd13, 14'd2004}, '{5'd1, 4'd1, 14'd2004}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b1, 1'b1}},
      '{'{'{5'd31, 4'd15, 14'd16383}, '{5'd31, 4'd15, 14'd16383}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b0, 1'b0}},
      '{'{'{5'd1, 4'd1, 14'd0}, '{5'd1, 4'd1, 14'd1}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b1, 1'b0}},
      '{'{'{5'd1, 4'd1, 14'd10000}, '{5'd1, 4'd1, 14'd1}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b1, 1'b0}},
      '{'{'{5'd1, 4'd1, 14'd1}, '{5'd0, 4'd0, 14'd0}}, 1'b1,
        '{22'd0, ERR_SECOND, 1'b0, 1'b1}},
      '{'{'{5'd1, 4'd1, 14'd1}, '{5'd1, 4'd1, 14'd10000}}, 1'b1,
        '{22'd0, ERR_SECOND, 1'b0, 1'b1}},
      '{'{'{5'd29, 4'd2, 14'd1900}, '{5'd1, 4'd3, 14'd1900}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b0, 1'b0}},
      '{'{'{5'd29, 4'd2, 14'd2000}, '{5'd1, 4'd3, 14'd2000}}, 1'b0, NO_RES},
      '{'{'{5'd28, 4'd2, 14'd2023}, '{5'd1, 4'd3, 14'd2023}}, 1'b0, NO_RES},
      '{'{'{5'd29, 4'd2, 14'd2024}, '{5'd29, 4'd2, 14'd2028}}, 1'b0, NO_RES},
      '{'{'{5'd31, 4'd4, 14'd2021}, '{5'd1, 4'd5, 14'd2021}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b0, 1'b0}},
      '{'{'{5'd1, 4'd5, 14'd2021}, '{5'd31, 4'd6, 14'd2021}}, 1'b1,
        '{22'd0, ERR_SECOND, 1'b0, 1'b0}},
      '{'{'{5'd0, 4'd0, 14'd0}, '{5'd0, 4'd0, 14'd0}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b1, 1'b1}},
      '{'{'{5'd2, 4'd1, 14'd2020}, '{5'd1, 4'd1, 14'd2020}}, 1'b1,
        '{22'd0, ERR_ORDER, 1'b1, 1'b1}},
      '{'{'{5'd31, 4'd12, 14'd1999}, '{5'd1, 4'd1, 14'd2000}}, 1'b0, NO_RES},
      '{'{'{5'd1, 4'd3, 14'd1600}, '{5'd28, 4'd2, 14'd1601}}, 1'b0, NO_RES},
      '{'{'{5'd15, 4'd8, 14'd1947}, '{5'd26, 4'd1, 14'd1950}}, 1'b0, NO_RES},
      '{'{'{5'd31, 4'd1, 14'd2022}, '{5'd28, 4'd2, 14'd2022}}, 1'b0, NO_RES},
      '{'{'{5'd29, 4'd2, 14'd2100}, '{5'd29, 4'd2, 14'd2400}}, 1'b1,
        '{22'd0, ERR_FIRST, 1'b0, 1'b1}}
   };

   logic                clock;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic [DAY_W-1:0]    req_first_day    = '0;
   logic [MONTH_W-1:0]  req_first_month  = '0;
   logic [YEAR_W-1:0]   req_first_year   = '0;
   logic [DAY_W-1:0]    req_second_day   = '0;
   logic [MONTH_W-1:0]  req_second_month = '0;
   logic [YEAR_W-1:0]   req_second_year  = '0;
   logic                busy;
   logic                rsp_valid;
   logic [DAYS_W-1:0]   rsp_days_between;
   logic [ERR_W-1:0]    rsp_error_code;
   logic                rsp_first_is_leap;
   logic                rsp_second_is_leap;

   day_count_type pending_counts[$];
   int unsigned   fail_count = 0;
   int unsigned   idle_pct   = 0;

   date_difference_in_days #(
      .MAX_YEAR(YEAR_LIMIT)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_day      (req_first_day),
      .req_first_month    (req_first_month),
      .req_first_year     (req_first_year),
      .req_second_day     (req_second_day),
      .req_second_month   (req_second_month),
      .req_second_year    (req_second_year),
      .rsp_valid          (rsp_valid),
      .rsp_days_between   (rsp_days_between),
      .rsp_error_code     (rsp_error_code),
      .rsp_first_is_leap  (rsp_first_is_leap),
      .rsp_second_is_leap (rsp_second_is_leap)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("** date_difference_in_days: FAILED **");
      $finish;
   end

   function automatic bit leap_year(input int unsigned y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic bit date_ok(input cal_date_type dt);
      if (dt.month < 1 || dt.month > 12) return 1'b0;
      if (dt.year < 1 || dt.year > YEAR_LIMIT) return 1'b0;
      return dt.day >= 1 && dt.day <= days_in_month(dt.month, leap_year(dt.year));
   endfunction

   // days since 1 March of year 0
   function automatic int unsigned day_index(input cal_date_type dt);
      int unsigned yy, era, yoe, mp, doy;
      yy  = (dt.month <= 2) ? dt.year - 1 : dt.year;
      era = yy / 400;
      yoe = yy - era * 400;
      mp  = (dt.month > 2) ? dt.month - 3 : dt.month + 9;
      doy = (153 * mp + 2) / 5 + dt.day - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
   endfunction

   function automatic day_count_type count_days(input date_pair_type p);
      day_count_type r;
      int unsigned   n1, n2;
      r = '0;
      r.first_is_leap  = leap_year(p.first.year);
      r.second_is_leap = leap_year(p.second.year);
      if (!date_ok(p.first)) begin
         r.error_code = ERR_FIRST;
      end else if (!date_ok(p.second)) begin
         r.error_code = ERR_SECOND;
      end else begin
         n1 = day_index(p.first);
         n2 = day_index(p.second);
         if (n2 < n1) begin
            r.error_code = ERR_ORDER;
         end else begin
            r.error_code   = ERR_OK;
            r.days_between = DAYS_W'((n2 - n1 > DAYS_SAT) ? DAYS_SAT : n2 - n1);
         end
      end
      return r;
   endfunction

   function automatic cal_date_type random_valid_date();
      cal_date_type dt;
      int unsigned  k;
      k = $urandom_range(0, 9);
      if (k < 2)      dt.year = YEAR_W'($urandom_range(1, 40));
      else if (k < 4) dt.year = YEAR_W'($urandom_range(YEAR_LIMIT - 40, YEAR_LIMIT));
      else            dt.year = YEAR_W'($urandom_range(1, YEAR_LIMIT));
      dt.month = MONTH_W'($urandom_range(1, 12));
      dt.day   = DAY_W'($urandom_range(1, days_in_month(dt.month, leap_year(dt.year))));
      return dt;
   endfunction

   function automatic cal_date_type random_edge_date();
      cal_date_type dt;
      int unsigned  len;
      dt.year  = YEAR_W'(EDGE_YEARS[$urandom_range(0, 11)] + $urandom_range(0, 1));
      dt.month = MONTH_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 12));
      len      = days_in_month(dt.month, leap_year(dt.year));
      case ($urandom_range(0, 4))
         0:       dt.day = '0;
         1:       dt.day = 5'd1;
         2:       dt.day = DAY_W'(len);
         3:       dt.day = DAY_W'((len < 31) ? len + 1 : 31);
         default: dt.day = DAY_W'($urandom_range(0, 31));
      endcase
      return dt;
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type p;
      cal_date_type  tmp;
      day_count_type chk;
      logic [63:0]   raw;
      int unsigned   k;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         p.first  = random_valid_date();
         p.second = random_valid_date();
         chk      = count_days(p);
         if ($urandom_range(0, 5) != 0 && chk.error_code == ERR_ORDER) begin
            tmp      = p.first;
            p.first  = p.second;
            p.second = tmp;
         end
      end else if (k < 60) begin
         p.first       = random_valid_date();
         p.second      = p.first;
         p.second.year = YEAR_W'(p.first.year + $urandom_range(0, 2));
         if (p.second.year > YEAR_LIMIT) p.second.year = YEAR_W'(YEAR_LIMIT);
         p.second.day  = DAY_W'($urandom_range(1, 31));
      end else if (k < 80) begin
         p.first  = random_edge_date();
         p.second = random_edge_date();
      end else begin
         raw = {$urandom, $urandom};
         p   = raw[$bits(date_pair_type)-1:0];
      end
      return p;
   endfunction

   task automatic send_request(input date_pair_type p, input bit typed,
                               input day_count_type res);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start            <= 1'b1;
      req_first_day    <= p.first.day;
      req_first_month  <= p.first.month;
      req_first_year   <= p.first.year;
      req_second_day   <= p.second.day;
      req_second_month <= p.second.month;
      req_second_year  <= p.second.year;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_counts.push_back(typed ? res : count_days(p));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      day_count_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_counts.size() == 0) begin
               $display("%0t unexpected result: expected none, got days %0d err %0d",
                        $time, rsp_days_between, rsp_error_code);
               fail_count++;
            end else begin
               want = pending_counts.pop_front();
               check_field("days_between", 32'(want.days_between),
                           32'(rsp_days_between));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("first_is_leap", 32'(want.first_is_leap),
                           32'(rsp_first_is_leap));
               check_field("second_is_leap", 32'(want.second_is_leap),
                           32'(rsp_second_is_leap));
            end
         end else if (rsp_valid !== 1'b0) begin
            $display("%0t rsp_valid: expected 0, got %b", $time, rsp_valid);
            fail_count++;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 17;
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_request(DIRECTED_ROWS[i].pair, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            drain();
            idle_pct = 57;
         end else if (i == 2 * N_RANDOM / 3) begin
            drain();
            idle_pct = 0;
         end
         send_request(random_pair(), 1'b0, NO_RES);
      end
      drain();
      repeat (PIPE_DEPTH + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("** date_difference_in_days: PASSED **");
      end else begin
         $display("** date_difference_in_days: FAILED **");
      end
      $finish;
   end

endmodule
